@@ rtl/core/tsm_pkg.sv @@
`default_nettype none
package tsm_pkg;

	localparam int NEEDLE_MAX      = 32;
	localparam int NEEDLE_REGS     = 4;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ROW_W           = 16;
	localparam int COL_W           = 12;
	localparam int END_W           = COL_W + 1;
	localparam int IDX_W           = 10;
	localparam int TOT_W           = 11;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_W           = 6;

	// command codes
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_TEXT   = 3'd1;
	localparam logic [2:0] CMD_FINISH = 3'd2;
	localparam logic [2:0] CMD_NEXT   = 3'd3;
	localparam logic [2:0] CMD_PREV   = 3'd4;
	localparam logic [2:0] CMD_QUERY  = 3'd5;

	// cell states
	localparam logic [1:0] CELL_NONE   = 2'd0;
	localparam logic [1:0] CELL_HIGH   = 2'd1;
	localparam logic [1:0] CELL_ACTIVE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CASE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR  = 3'd7;

	typedef struct packed {
		logic [2:0]       command;
		logic [7:0]       text_byte;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic             match_valid;
		logic [ROW_W-1:0] match_row;
		logic [COL_W-1:0] match_start;
		logic [END_W-1:0] match_end;
		logic             active_valid;
		logic [IDX_W-1:0] active_index;
		logic [TOT_W-1:0] match_total;
		logic [1:0]       cell_state;
		logic             table_full;
	} out_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] start;
		logic [END_W-1:0] stop;
	} tbl_entry_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic text;
		logic scan_start;
		logic scan_rd;
		logic scan_next;
		logic scan_hit;
		logic scan_wrap;
		logic act_rd;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       count_zero;
		logic       idx_last;
		logic       hit;
		logic       out_free;
	} ctl_sts_t;

	function automatic logic [7:0] fold(input logic [7:0] b, input logic cs);
		logic [7:0] r;
		r = b;
		if (!cs && (b inside {[8'h41:8'h5A]})) r = b + 8'd32;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/tsm_ctrl.sv @@
`default_nettype none
module tsm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [2:0]           in_cmd,
	output logic                      in_stall,
	input  wire tsm_pkg::ctl_sts_t    sts,
	output tsm_pkg::ctl_cmd_t         ctl
);
	import tsm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EXEC  = 8'b0000_0010,
		ST_TEXT  = 8'b0000_0100,
		ST_SINIT = 8'b0000_1000,
		ST_SRD   = 8'b0001_0000,
		ST_SCHK  = 8'b0010_0000,
		ST_ACTRD = 8'b0100_0000,
		ST_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_n = state_q;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.take = 1'b1;
					if (in_cmd == CMD_TEXT) state_n = ST_TEXT;
					else if (in_cmd == CMD_FINISH || in_cmd == CMD_QUERY) state_n = ST_SINIT;
					else state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_n = ST_ACTRD;
			end
			ST_TEXT: begin
				ctl.text = 1'b1;
				state_n = ST_RESP;
			end
			ST_SINIT: begin
				ctl.scan_start = 1'b1;
				if (sts.count_zero) state_n = ST_ACTRD;
				else state_n = ST_SRD;
			end
			ST_SRD: begin
				ctl.scan_rd = 1'b1;
				state_n = ST_SCHK;
			end
			ST_SCHK: begin
				if (sts.hit) begin
					ctl.scan_hit = 1'b1;
					state_n = ST_ACTRD;
				end else if (sts.idx_last) begin
					ctl.scan_wrap = 1'b1;
					state_n = ST_ACTRD;
				end else begin
					ctl.scan_next = 1'b1;
					state_n = ST_SRD;
				end
			end
			ST_ACTRD: begin
				ctl.act_rd = 1'b1;
				state_n = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

endmodule
`default_nettype wire

@@ rtl/core/tsm_dp.sv @@
`default_nettype none
module tsm_dp #(
	parameter int TABLE_DEPTH = tsm_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tsm_pkg::in_item_t                 in_data,
	input  wire logic                              cfg_we,
	input  wire logic [tsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire tsm_pkg::ctl_cmd_t                 ctl,
	output tsm_pkg::ctl_sts_t                      sts,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output tsm_pkg::out_item_t                     out_data
);
	import tsm_pkg::*;

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int CW = SW + 1;
	localparam int NB = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

	logic [NEEDLE_REGS-1:0][CFG_DATA_W-1:0] needle_q;
	logic [LEN_W-1:0]  nlen_q;
	logic              csens_q, wrap_q;
	logic [ROW_W-1:0]  cursor_q;

	logic [NEEDLE_MAX-1:0][7:0] window_q, win_n;
	logic [LEN_W-1:0]  fill_q, fill_base, fill_n;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     slot_q, idx_q, raddr;
	logic              present_q, ovf_q;
	in_item_t          item_q;
	logic              own_q, found_q;
	logic [ROW_W-1:0]  mrow_q;
	logic [COL_W-1:0]  mstart_q;
	logic [END_W-1:0]  mend_q;
	logic [1:0]        cell_q;
	tbl_entry_t        tbl_mem [TABLE_DEPTH];
	tbl_entry_t        rdata_q;
	logic              out_valid_q;
	out_item_t         out_q, out_n;

	logic [NEEDLE_MAX-1:0][7:0] needle_b;
	logic [LEN_W-1:0]  len;
	logic              mism, text_hit, room;
	logic [END_W-1:0]  col_p1;
	logic [COL_W-1:0]  m_start;
	logic [CW-1:0]     slot_p1, idx_p1, cnt_m1;
	logic [31:0]       slot_w, count_w;
	tbl_entry_t        wr_ent;

	for (genvar g = 0; g < NEEDLE_MAX; g++) begin : g_nb
		assign needle_b[g] = needle_q[g / 8][(g % 8) * 8 +: 8];
	end

	// effective length, clamp to window size
	assign len = (nlen_q > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : nlen_q;

	// window and fill after this byte
	always_comb begin
		fill_base = (item_q.column == '0) ? '0 : fill_q;
		win_n = window_q;
		fill_n = '0;
		if (item_q.text_byte != 8'd0) begin
			for (int k = NEEDLE_MAX - 1; k > 0; k--) win_n[k] = window_q[k - 1];
			win_n[0] = item_q.text_byte;
			fill_n = (fill_base < LEN_W'(NEEDLE_MAX)) ? fill_base + LEN_W'(1) : fill_base;
		end
	end

	// window position k holds needle byte len-1-k
	always_comb begin
		logic [LEN_W-1:0] j;
		mism = 1'b0;
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			j = len - LEN_W'(k + 1);
			if (LEN_W'(k) < len &&
			    fold(win_n[k], csens_q) != fold(needle_b[j[NB-1:0]], csens_q))
				mism = 1'b1;
		end
	end

	assign col_p1   = {1'b0, item_q.column} + END_W'(1);
	assign m_start  = COL_W'(col_p1 - END_W'(len));
	assign text_hit = (item_q.text_byte != 8'd0) && (len != '0) && (fill_n >= len) &&
	                  (col_p1 >= END_W'(len)) && !mism;
	assign room     = count_q < CW'(TABLE_DEPTH);
	assign slot_p1  = {1'b0, slot_q} + CW'(1);
	assign idx_p1   = {1'b0, idx_q} + CW'(1);
	assign cnt_m1   = count_q - CW'(1);
	assign raddr    = ctl.act_rd ? slot_q : idx_q;
	assign wr_ent   = '{row: item_q.row, start: m_start, stop: col_p1};

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.text && text_hit && room) tbl_mem[count_q[SW-1:0]] <= wr_ent;
		if (ctl.act_rd || ctl.scan_rd) rdata_q <= tbl_mem[raddr];
	end

	always_comb begin
		sts.cmd        = item_q.command;
		sts.count_zero = (count_q == '0);
		sts.idx_last   = (idx_p1 >= count_q);
		sts.out_free   = !out_valid_q || !out_stall;
		if (item_q.command == CMD_FINISH)
			sts.hit = (rdata_q.row >= cursor_q);
		else
			sts.hit = (rdata_q.row == item_q.row) && (item_q.column >= rdata_q.start) &&
			          ({1'b0, item_q.column} < rdata_q.stop);
	end

	assign slot_w  = 32'(slot_q);
	assign count_w = 32'(count_q);

	always_comb begin
		out_n = '0;
		if (own_q) begin
			out_n.found       = found_q;
			out_n.match_valid = found_q;
			out_n.match_row   = mrow_q;
			out_n.match_start = mstart_q;
			out_n.match_end   = mend_q;
		end else if (present_q && ({1'b0, slot_q} < count_q)) begin
			out_n.match_valid = 1'b1;
			out_n.match_row   = rdata_q.row;
			out_n.match_start = rdata_q.start;
			out_n.match_end   = rdata_q.stop;
		end
		out_n.active_valid = present_q;
		out_n.active_index = present_q ? slot_w[IDX_W-1:0] : '0;
		out_n.match_total  = count_w[TOT_W-1:0];
		out_n.cell_state   = cell_q;
		out_n.table_full   = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q    <= '0;
			nlen_q      <= '0;
			csens_q     <= 1'b0;
			wrap_q      <= 1'b0;
			cursor_q    <= '0;
			window_q    <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			slot_q      <= '0;
			present_q   <= 1'b0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			own_q       <= 1'b0;
			found_q     <= 1'b0;
			cell_q      <= CELL_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NEEDLE0: needle_q[0] <= cfg_data;
					REG_NEEDLE1: needle_q[1] <= cfg_data;
					REG_NEEDLE2: needle_q[2] <= cfg_data;
					REG_NEEDLE3: needle_q[3] <= cfg_data;
					REG_LENGTH:  nlen_q      <= cfg_data[LEN_W-1:0];
					REG_CASE:    csens_q     <= cfg_data[0];
					REG_WRAP:    wrap_q      <= cfg_data[0];
					REG_CURSOR:  cursor_q    <= cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (ctl.take) begin
				own_q   <= 1'b0;
				found_q <= 1'b0;
				cell_q  <= CELL_NONE;
			end
			if (ctl.exec) begin
				case (item_q.command)
					CMD_CLEAR: begin
						window_q  <= '0;
						fill_q    <= '0;
						count_q   <= '0;
						slot_q    <= '0;
						present_q <= 1'b0;
						ovf_q     <= 1'b0;
					end
					CMD_NEXT, CMD_PREV: begin
						if (count_q != '0) begin
							if (!present_q) begin
								slot_q    <= '0;
								present_q <= 1'b1;
							end else if (item_q.command == CMD_NEXT) begin
								if (slot_p1 < count_q) slot_q <= slot_p1[SW-1:0];
								else if (wrap_q) slot_q <= '0;
							end else begin
								if (slot_q != '0) slot_q <= slot_q - SW'(1);
								else if (wrap_q) slot_q <= cnt_m1[SW-1:0];
							end
						end
					end
					default: ;
				endcase
			end
			if (ctl.text) begin
				own_q    <= 1'b1;
				found_q  <= text_hit;
				window_q <= win_n;
				fill_q   <= fill_n;
				if (text_hit) begin
					if (room) count_q <= count_q + CW'(1);
					else ovf_q <= 1'b1;
				end
			end
			if (ctl.scan_start) begin
				idx_q <= '0;
				if (item_q.command == CMD_FINISH) begin
					present_q <= 1'b0;
					slot_q    <= '0;
				end
			end
			if (ctl.scan_next) idx_q <= idx_p1[SW-1:0];
			if (ctl.scan_hit) begin
				if (item_q.command == CMD_FINISH) begin
					present_q <= 1'b1;
					slot_q    <= idx_q;
				end else begin
					cell_q <= (present_q && idx_q == slot_q) ? CELL_ACTIVE : CELL_HIGH;
				end
			end
			if (ctl.scan_wrap && item_q.command == CMD_FINISH && wrap_q) begin
				present_q <= 1'b1;
				slot_q    <= '0;
			end
			if (ctl.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.take) item_q <= in_data;
		if (ctl.text) begin
			mrow_q   <= text_hit ? item_q.row : '0;
			mstart_q <= text_hit ? m_start : '0;
			mend_q   <= text_hit ? col_p1 : '0;
		end
		if (ctl.load_out) out_q <= out_n;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("table count beyond depth");
	a_active_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		present_q |-> ({1'b0, slot_q} < count_q)) else $error("active slot outside table");
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CW'(TABLE_DEPTH))) else $error("overflow with room left");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || !out_stall)) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

@@ rtl/core/text_search_match_table_top.sv @@
`default_nettype none
// Channel   Direction  Handshake           Payload
// in        request    in_valid/in_stall   in_data  (tsm_pkg::in_item_t)
// out       result     out_valid/out_stall out_data (tsm_pkg::out_item_t)
// cfg       write      cfg_we              cfg_index, cfg_data
//
// One request at a time. A text byte passes TEXT and RESP; clear, next and
// previous pass EXEC, ACTRD (one table read for the active match) and RESP.
// Finish and cell query walk the table through its single read port, SRD and
// SCHK per entry, then ACTRD and RESP. Reset clears all control state and the
// configuration registers, not payload ones; the table needs no clearing. A
// stalled result holds in the output register as the next request is taken.
module text_search_match_table_top #(
	parameter int TABLE_DEPTH = tsm_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire tsm_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output tsm_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_we,
	input  wire logic [tsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tsm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsm_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	// sequence each request: latch, compute or walk the table, then publish
	tsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.command),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// window compare, match table, selection state and output register
	tsm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
